### sv/assert_macros.svh
// Assertion helpers used by the decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/tvsd_pkg.sv
package tvsd_pkg;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VALUE   = 3'd1,
        PH_LEN_TAG = 3'd2,
        PH_LEN     = 3'd3,
        PH_CHARS   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        KIND_I8    = 3'd0,
        KIND_I16   = 3'd1,
        KIND_I32   = 3'd2,
        KIND_LONG  = 3'd3,
        KIND_LLONG = 3'd4,
        KIND_SLEN  = 3'd5,
        KIND_SCHAR = 3'd6,
        KIND_ERR   = 3'd7
    } t_kind;

    localparam t_byte TAG_I8    = 8'd1;
    localparam t_byte TAG_I16   = 8'd2;
    localparam t_byte TAG_I32   = 8'd3;
    localparam t_byte TAG_LONG  = 8'd4;
    localparam t_byte TAG_LLONG = 8'd5;
    localparam t_byte TAG_STR   = 8'd6;

    localparam logic [63:0] ERR_TAG     = 64'd0;
    localparam logic [63:0] ERR_LEN_TAG = 64'd1;
    localparam logic [63:0] ERR_NEG_LEN = 64'd2;

    typedef struct packed {
        t_kind              kind;
        logic signed [63:0] value;
        logic               last;
    } t_result;

endpackage

### sv/tvsd_byte_if.sv
interface tvsd_byte_if;
    import tvsd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

### sv/tvsd_res_if.sv
interface tvsd_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         value_kind;
    logic signed [63:0] value;
    logic               last_of_string;

    modport source (output valid, output value_kind, output value, output last_of_string,
                    input ready);
    modport sink   (input valid, input value_kind, input value, input last_of_string,
                    output ready);
endinterface

### sv/tagged_value_stream_decoder_top.sv
// Decodes a little-endian byte stream of type-tagged values, one byte per beat, and returns
// one result beat per finished value, per string length and per string character, or an
// error beat for a bad tag, a missing length tag or a negative length. It sustains one byte
// per clock unless the output register is held full: the byte is registered at the
// input, the phase, count and accumulator update in one pass of logic, and the result is
// registered at the output, offered on the cycle after the core takes its last byte. Input
// ready only drops while the output register is held full and the waiting byte would
// produce a result. The long-length setting applies from the next long tag onward; the user
// must write it on the configuration port only while no byte is in flight (not enforced).
module tagged_value_stream_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tvsd_byte_if.sink  i_byte,
    tvsd_res_if.source o_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import tvsd_pkg::*;

    logic    in_valid;
    t_byte   in_byte;
    logic    take;
    logic    load;
    logic    out_free;
    t_result res;

    assign o_cfg_ready = 1'b1;

    tvsd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    tvsd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_valid    (in_valid),
        .i_byte     (in_byte),
        .i_out_free (out_free),
        .o_take     (take),
        .o_load     (load),
        .o_res      (res)
    );

    tvsd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .o_free  (out_free),
        .o_res   (o_res)
    );
endmodule

### sv/tvsd_in_reg.sv
module tvsd_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tvsd_byte_if.sink     i_byte,
    input  logic          i_take,
    output logic          o_valid,
    output tvsd_pkg::t_byte o_byte
);
    import tvsd_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_byte r_byte;

    // A new beat is taken when the stage is empty or its byte moves on this cycle.
    assign i_byte.ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_byte.valid && i_byte.ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_byte <= i_byte.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

### sv/tvsd_core.sv
`include "assert_macros.svh"

module tvsd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic              i_valid,
    input  tvsd_pkg::t_byte   i_byte,
    input  logic              i_out_free,
    output logic              o_take,
    output logic              o_load,
    output tvsd_pkg::t_result o_res
);
    import tvsd_pkg::*;

    t_phase      r_phase, n_phase;
    t_kind       r_kind, n_kind;
    logic [2:0]  r_bytes, n_bytes;
    logic [63:0] r_acc, n_acc;
    logic [14:0] r_chars, n_chars;
    logic        r_long4, n_long4;
    logic        r_long_cfg;

    logic        res_valid;
    t_result     res;
    logic [63:0] acc_ins;
    logic [2:0]  last_idx;
    logic [15:0] len;

    function automatic logic [63:0] finish_value(t_kind kind, logic [63:0] acc, logic long4);
        logic [63:0] result;
        result = acc;
        unique case (kind)
            KIND_I8:   result = {56'd0, acc[7:0]};
            KIND_I16:  result = {{48{acc[15]}}, acc[15:0]};
            KIND_I32:  result = acc[31] ? (64'd0 - {33'd0, acc[30:0]}) : {33'd0, acc[30:0]};
            KIND_LONG: result = long4 ? {{32{acc[31]}}, acc[31:0]} : acc;
            default:   result = acc;
        endcase
        return result;
    endfunction

    // Little-endian assembly: the current byte lands in the lane that the count selects.
    always_comb begin
        acc_ins = r_acc;
        for (int i = 0; i < 8; i++) begin
            if (r_bytes == 3'(i)) begin
                acc_ins[8*i +: 8] = i_byte;
            end
        end
    end

    always_comb begin
        unique case (r_kind)
            KIND_I8:   last_idx = 3'd0;
            KIND_I16:  last_idx = 3'd1;
            KIND_I32:  last_idx = 3'd3;
            KIND_LONG: last_idx = r_long4 ? 3'd3 : 3'd7;
            default:   last_idx = 3'd7;
        endcase
    end

    assign len = {i_byte, r_acc[7:0]};

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_bytes   = r_bytes;
        n_acc     = r_acc;
        n_chars   = r_chars;
        n_long4   = r_long4;
        res_valid = 1'b0;
        res       = '{kind: KIND_ERR, value: '0, last: 1'b0};

        unique case (r_phase)
            PH_TAG: begin
                n_bytes = '0;
                n_acc   = '0;
                case (i_byte) inside
                    [TAG_I8:TAG_LLONG]: begin
                        n_kind  = t_kind'(3'(i_byte - TAG_I8));
                        n_phase = PH_VALUE;
                        if (i_byte == TAG_LONG) begin
                            n_long4 = r_long_cfg;
                        end
                    end
                    TAG_STR: begin
                        n_kind  = KIND_SLEN;
                        n_phase = PH_LEN_TAG;
                    end
                    default: begin
                        res_valid = 1'b1;
                        res.value = ERR_TAG;
                    end
                endcase
            end
            PH_VALUE: begin
                n_acc = acc_ins;
                if (r_bytes == last_idx) begin
                    res_valid  = 1'b1;
                    res.kind   = r_kind;
                    res.value  = finish_value(r_kind, acc_ins, r_long4);
                    n_phase    = PH_TAG;
                    n_bytes    = '0;
                end else begin
                    n_bytes = r_bytes + 3'd1;
                end
            end
            PH_LEN_TAG: begin
                if (i_byte == TAG_I16) begin
                    n_bytes = '0;
                    n_acc   = '0;
                    n_phase = PH_LEN;
                end else begin
                    n_phase   = PH_TAG;
                    res_valid = 1'b1;
                    res.value = ERR_LEN_TAG;
                end
            end
            PH_LEN: begin
                n_acc = acc_ins;
                if (r_bytes[0] == 1'b0) begin
                    n_bytes = 3'd1;
                end else begin
                    n_bytes   = '0;
                    res_valid = 1'b1;
                    if (len[15]) begin
                        n_phase   = PH_TAG;
                        res.value = ERR_NEG_LEN;
                    end else begin
                        n_chars  = len[14:0];
                        res.kind = KIND_SLEN;
                        res.value = {48'd0, len};
                        if (len == 16'd0) begin
                            n_phase  = PH_TAG;
                            res.last = 1'b1;
                        end else begin
                            n_phase = PH_CHARS;
                            n_kind  = KIND_SCHAR;
                        end
                    end
                end
            end
            PH_CHARS: begin
                n_chars   = r_chars - 15'd1;
                res_valid = 1'b1;
                res.kind  = KIND_SCHAR;
                res.value = {56'd0, i_byte};
                if (r_chars == 15'd1) begin
                    n_phase  = PH_TAG;
                    res.last = 1'b1;
                end
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase
    end

    // A byte that yields a result waits until the result register has room.
    assign o_take = i_valid && (!res_valid || i_out_free);
    assign o_load = o_take && res_valid;
    assign o_res  = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG;
            r_kind     <= KIND_I8;
            r_bytes    <= '0;
            r_acc      <= '0;
            r_chars    <= '0;
            r_long4    <= 1'b0;
            r_long_cfg <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase <= n_phase;
                r_kind  <= n_kind;
                r_bytes <= n_bytes;
                r_acc   <= n_acc;
                r_chars <= n_chars;
                r_long4 <= n_long4;
            end
            if (i_cfg_we) begin
                r_long_cfg <= i_cfg_data;
            end
        end
    end

    `ASSERT_IMPL(a_chars_nonzero, i_clk, i_rst_n, r_phase == PH_CHARS, r_chars != 15'd0)
    `ASSERT_IMPL(a_len_count, i_clk, i_rst_n, r_phase == PH_LEN, r_bytes <= 3'd1)
    `ASSERT_NEXT(a_str_tag, i_clk, i_rst_n,
                 o_take && r_phase == PH_TAG && i_byte == TAG_STR, r_phase == PH_LEN_TAG)
    `ASSERT_IMPL(a_tag_no_stall, i_clk, i_rst_n,
                 i_valid && r_phase == PH_TAG && i_byte >= TAG_I8 && i_byte <= TAG_STR, o_take)
endmodule

### sv/tvsd_out_reg.sv
module tvsd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tvsd_pkg::t_result i_res,
    output logic              o_free,
    tvsd_res_if.source        o_res
);
    import tvsd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Room for a new result when empty or when the held one leaves this cycle.
    assign o_free = !r_valid || o_res.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.value_kind     = r_res.kind;
    assign o_res.value          = r_res.value;
    assign o_res.last_of_string = r_res.last;
endmodule

### verif/tb_tagged_value_stream_decoder_top.sv
module tb_tagged_value_stream_decoder_top;
    import tvsd_pkg::*;

    localparam int LIMIT_CYCLES = 200_000;
    localparam int TAIL_CYCLES  = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 110;

    typedef struct {
        t_byte   b;
        bit      typed;
        t_result res;
    } t_stim_row;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;

    tvsd_byte_if byte_ch();
    tvsd_res_if  res_ch();

    tagged_value_stream_decoder_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_byte      (byte_ch),
        .o_res       (res_ch),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // Decoder state as the testbench sees it.
    t_phase      dec_phase;
    t_kind       dec_kind;
    logic [3:0]  dec_seen;
    logic [63:0] dec_acc;
    logic [14:0] dec_chars_left;
    logic        long_four_reg;
    logic        long_four_held;

    t_result   due_values[$];
    t_stim_row offered_rows[$];
    t_stim_row dir_rows[$];

    int mismatches;
    int bytes_in;
    int bytes_offered;
    int results_out;
    int kind_count[8];
    int cfg_writes;
    int cycles;
    int hold_reqs;
    bit src_idle_en;
    bit sink_idle_en;
    bit long_mode;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tagged_value_stream_decoder_top test failed");
            $finish;
        end
    end

    function automatic void note_value(input t_kind k, input logic [63:0] v, input logic last);
        t_result r;
        r.kind  = k;
        r.value = v;
        r.last  = last;
        due_values.push_back(r);
    endfunction

    function automatic void decode_byte(input t_byte b);
        logic [63:0] v;
        logic [63:0] mag;
        logic [15:0] len;
        int          need;
        case (dec_phase)
            PH_TAG: begin
                dec_seen = '0;
                dec_acc  = '0;
                if (b >= TAG_I8 && b <= TAG_LLONG) begin
                    dec_kind = t_kind'(3'(b - TAG_I8));
                    // The long width is fixed by the setting in force when its tag arrives.
                    if (b == TAG_LONG)
                        long_four_held = long_four_reg;
                    dec_phase = PH_VALUE;
                end else if (b == TAG_STR) begin
                    dec_kind  = KIND_SLEN;
                    dec_phase = PH_LEN_TAG;
                end else begin
                    note_value(KIND_ERR, ERR_TAG, 1'b0);
                end
            end
            PH_VALUE: begin
                dec_acc  = dec_acc | ({56'd0, b} << (8 * dec_seen[2:0]));
                dec_seen = dec_seen + 4'd1;
                case (dec_kind)
                    KIND_I8:   need = 1;
                    KIND_I16:  need = 2;
                    KIND_I32:  need = 4;
                    KIND_LONG: need = long_four_held ? 4 : 8;
                    default:   need = 8;
                endcase
                if (dec_seen >= need) begin
                    case (dec_kind)
                        KIND_I8:  v = {56'd0, dec_acc[7:0]};
                        KIND_I16: v = {{48{dec_acc[15]}}, dec_acc[15:0]};
                        KIND_I32: begin
                            mag = {33'd0, dec_acc[30:0]};
                            v   = dec_acc[31] ? -mag : mag;
                        end
                        KIND_LONG: v = long_four_held ? {{32{dec_acc[31]}}, dec_acc[31:0]}
                                                      : dec_acc;
                        default:  v = dec_acc;
                    endcase
                    note_value(dec_kind, v, 1'b0);
                    dec_phase = PH_TAG;
                    dec_seen  = '0;
                end
            end
            PH_LEN_TAG: begin
                if (b == TAG_I16) begin
                    dec_seen  = '0;
                    dec_acc   = '0;
                    dec_phase = PH_LEN;
                end else begin
                    dec_phase = PH_TAG;
                    note_value(KIND_ERR, ERR_LEN_TAG, 1'b0);
                end
            end
            PH_LEN: begin
                dec_acc  = dec_acc | ({56'd0, b} << (8 * dec_seen[0]));
                dec_seen = dec_seen + 4'd1;
                if (dec_seen >= 2) begin
                    dec_seen = '0;
                    len      = dec_acc[15:0];
                    if (len[15]) begin
                        dec_phase = PH_TAG;
                        note_value(KIND_ERR, ERR_NEG_LEN, 1'b0);
                    end else begin
                        dec_chars_left = len[14:0];
                        if (len == 16'd0) begin
                            dec_phase = PH_TAG;
                            note_value(KIND_SLEN, 64'd0, 1'b1);
                        end else begin
                            dec_phase = PH_CHARS;
                            dec_kind  = KIND_SCHAR;
                            note_value(KIND_SLEN, {48'd0, len}, 1'b0);
                        end
                    end
                end
            end
            PH_CHARS: begin
                if (dec_chars_left != '0)
                    dec_chars_left = dec_chars_left - 15'd1;
                if (dec_chars_left == '0) begin
                    dec_phase = PH_TAG;
                    note_value(KIND_SCHAR, {56'd0, b}, 1'b1);
                end else begin
                    note_value(KIND_SCHAR, {56'd0, b}, 1'b0);
                end
            end
            default: dec_phase = PH_TAG;
        endcase
    endfunction

    // Prediction on every input beat, then comparison of every output beat.
    always @(posedge clk) begin
        t_stim_row row;
        t_result   want;
        int        due_count;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                long_four_reg = cfg_data;
            if (byte_ch.valid && byte_ch.ready) begin
                due_count = due_values.size();
                decode_byte(byte_ch.data_byte);
                row = offered_rows.pop_front();
                // A hand-written expectation stands in place of the predicted one.
                if (row.typed) begin
                    if (due_values.size() == due_count)
                        due_values.push_back(row.res);
                    else
                        due_values[$] = row.res;
                end
                bytes_in++;
            end
            if (res_ch.valid && res_ch.ready) begin
                results_out++;
                kind_count[res_ch.value_kind]++;
                if (due_values.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected: kind %0d value %0d last %0b",
                             $time, res_ch.value_kind, res_ch.value, res_ch.last_of_string);
                end else begin
                    want = due_values.pop_front();
                    if (res_ch.value_kind !== want.kind) begin
                        mismatches++;
                        $display("%0t: value_kind expected %0d actual %0d",
                                 $time, want.kind, res_ch.value_kind);
                    end
                    if (res_ch.value !== want.value) begin
                        mismatches++;
                        $display("%0t: value expected %0d actual %0d",
                                 $time, want.value, res_ch.value);
                    end
                    if (res_ch.last_of_string !== want.last) begin
                        mismatches++;
                        $display("%0t: last_of_string expected %0b actual %0b",
                                 $time, want.last, res_ch.last_of_string);
                    end
                end
            end
        end
    end

    // Result sink: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= !(sink_idle_en && $urandom_range(0, 99) < 9);
            end
        end
    end

    function automatic t_byte rnd_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void plan_row(input t_byte b, input bit typed = 1'b0,
                                     input t_kind k = KIND_ERR, input logic [63:0] v = '0,
                                     input logic last = 1'b0);
        t_stim_row row;
        row.b          = b;
        row.typed      = typed;
        row.res.kind   = k;
        row.res.value  = v;
        row.res.last   = last;
        dir_rows.push_back(row);
    endfunction

    task automatic send_byte(input t_byte b, input bit typed = 1'b0, input t_result res = '0);
        t_stim_row row;
        int        gap;
        row.b     = b;
        row.typed = typed;
        row.res   = res;
        if (src_idle_en && $urandom_range(0, 99) < 4) begin
            gap = $urandom_range(1, 4);
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        offered_rows.push_back(row);
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        bytes_offered++;
        do @(posedge clk); while (!byte_ch.ready);
    endtask

    task automatic send_string(input logic [15:0] len);
        send_byte(TAG_STR);
        send_byte(TAG_I16);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (!len[15])
            repeat (int'(len)) send_byte(rnd_byte());
    endtask

    // One complete record; a random tag byte is completed as whatever it turns out to be.
    task automatic send_record();
        int    pick;
        int    n;
        t_byte tag;
        t_byte b;
        pick = $urandom_range(0, 99);
        if (pick < 12)      tag = TAG_I8;
        else if (pick < 24) tag = TAG_I16;
        else if (pick < 36) tag = TAG_I32;
        else if (pick < 48) tag = TAG_LONG;
        else if (pick < 60) tag = TAG_LLONG;
        else if (pick < 86) tag = TAG_STR;
        else                tag = t_byte'($urandom_range(0, 255));
        if (tag == TAG_STR) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_string(16'($urandom_range(0, 6)));
            end else if (pick < 78) begin
                send_string(16'($urandom_range(7, 300)));
            end else if (pick < 88) begin
                send_string(16'h8000 | 16'($urandom_range(0, 16'h7FFF)));
            end else begin
                send_byte(TAG_STR);
                do b = t_byte'($urandom_range(0, 255)); while (b == TAG_I16);
                send_byte(b);
            end
        end else begin
            case (tag)
                TAG_I8:    n = 1;
                TAG_I16:   n = 2;
                TAG_I32:   n = 4;
                TAG_LONG:  n = long_mode ? 4 : 8;
                TAG_LLONG: n = 8;
                default:   n = 0;
            endcase
            send_byte(tag);
            repeat (n) send_byte(rnd_byte());
        end
    endtask

    task automatic write_long_mode(input bit four);
        cfg_valid <= 1'b1;
        cfg_data  <= four;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        long_mode = four;
        cfg_writes++;
    endtask

    // The sender stops until every predicted result has come back and the pipe is empty.
    task automatic drain();
        byte_ch.valid <= 1'b0;
        do @(posedge clk); while (due_values.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic run_records(input int count);
        int target;
        target = bytes_offered + count;
        while (bytes_offered < target)
            send_record();
    endtask

    initial begin
        dec_phase      = PH_TAG;
        dec_kind       = KIND_I8;
        dec_seen       = '0;
        dec_acc        = '0;
        dec_chars_left = '0;
        long_four_reg  = 1'b0;
        long_four_held = 1'b0;
        long_mode      = 1'b0;
        src_idle_en    = 1'b1;
        sink_idle_en   = 1'b1;

        rst_n             <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_data          <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows, run with the four-byte long setting.
        write_long_mode(1'b1);
        plan_row(8'h00, 1'b1, KIND_ERR, ERR_TAG, 1'b0);
        plan_row(TAG_I8);
        plan_row(8'hFF, 1'b1, KIND_I8, 64'd255, 1'b0);
        plan_row(TAG_I16);
        plan_row(8'h00);
        plan_row(8'h80, 1'b1, KIND_I16, 64'hFFFF_FFFF_FFFF_8000, 1'b0);
        plan_row(TAG_I32);
        repeat (3) plan_row(8'h00);
        // Sign set with zero magnitude must come out as plain zero.
        plan_row(8'h80, 1'b1, KIND_I32, 64'd0, 1'b0);
        plan_row(TAG_LONG);
        repeat (3) plan_row(8'h00);
        plan_row(8'h80, 1'b1, KIND_LONG, 64'hFFFF_FFFF_8000_0000, 1'b0);
        plan_row(TAG_LLONG);
        repeat (7) plan_row(8'hFF);
        plan_row(8'h7F, 1'b1, KIND_LLONG, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        plan_row(TAG_STR);
        plan_row(8'h05, 1'b1, KIND_ERR, ERR_LEN_TAG, 1'b0);
        plan_row(TAG_STR);
        plan_row(TAG_I16);
        plan_row(8'hFF);
        plan_row(8'hFF, 1'b1, KIND_ERR, ERR_NEG_LEN, 1'b0);
        plan_row(TAG_STR);
        plan_row(TAG_I16);
        plan_row(8'h00);
        plan_row(8'h00, 1'b1, KIND_SLEN, 64'd0, 1'b1);
        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].res);
        drain();

        write_long_mode(1'b0);
        run_records(PHASE_ITEMS);
        drain();

        // A long stretch with neither side idling.
        write_long_mode(1'b1);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_records(PHASE_ITEMS);
        drain();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;

        // The sink holds off while a long string keeps the decoder busy, so it backs up.
        write_long_mode(1'b0);
        hold_reqs <= hold_reqs + 1;
        send_string(16'd60);
        run_records(PHASE_ITEMS);
        run_records(20);
        drain();

        $display("Covered %0d bytes, %0d results (%0d error beats, %0d string characters).",
                 bytes_in, results_out, kind_count[KIND_ERR], kind_count[KIND_SCHAR]);
        $display("Long tag run with %0d setting writes across both widths.", cfg_writes);
        if (mismatches == 0)
            $display("tagged_value_stream_decoder_top test passed");
        else
            $display("tagged_value_stream_decoder_top test failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/tvsd_pkg.sv
sv/tvsd_byte_if.sv
sv/tvsd_res_if.sv
sv/tvsd_in_reg.sv
sv/tvsd_core.sv
sv/tvsd_out_reg.sv
sv/tagged_value_stream_decoder_top.sv
verif/tb_tagged_value_stream_decoder_top.sv
